// ===== rtl/core/osfs_pkg.sv =====
// shared types, constants and helper functions of the servo controller
package osfs_pkg;

   // field and register widths
   localparam int SampleW  = 10;
   localparam int DriveW   = 10;
   localparam int GainW    = 20;
   localparam int LevelW   = 9;
   localparam int StateW   = 32;
   localparam int FracW    = 16;
   localparam int AccW     = 44;
   localparam int MulAW    = 38;
   localparam int MulBW    = GainW + 1;
   localparam int ProdW    = MulAW + MulBW;
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;
   localparam int RegIdxW  = CsrAddrW - 2;

   // multiply schedule of one control step
   localparam int StepCount = 10;
   localparam int StepW     = $clog2(StepCount);

   // plant model constants, Q16
   localparam logic [GainW-1:0] Phi11 = GainW'(65143);
   localparam logic [GainW-1:0] Phi21 = GainW'(16338);
   localparam logic [GainW-1:0] Gam1  = GainW'(7353);
   localparam logic [GainW-1:0] Gam2  = GainW'(918);

   // register reset values
   localparam logic [GainW-1:0]  GainPosReset   = GainW'(215600);
   localparam logic [GainW-1:0]  GainVelReset   = GainW'(116852);
   localparam logic [GainW-1:0]  GainRefReset   = GainW'(116852);
   localparam logic [GainW-1:0]  ObsOneReset    = GainW'(133438);
   localparam logic [GainW-1:0]  ObsTwoReset    = GainW'(81528);
   localparam logic [GainW-1:0]  ObsIntReset    = GainW'(210346);
   localparam logic [LevelW-1:0] RefLevelReset  = LevelW'(50);

   // drive limits in accumulator width
   localparam logic signed [AccW-1:0] DriveMaxAcc = AccW'(511);
   localparam logic signed [AccW-1:0] DriveMinAcc = AccW'(-512);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_FLIP  = 2'd3
   } osfs_opcode_type;

   typedef enum logic [RegIdxW-1:0] {
      REG_GAIN_POS        = 3'd0,
      REG_GAIN_VEL        = 3'd1,
      REG_GAIN_REF        = 3'd2,
      REG_OBS_GAIN_ONE    = 3'd3,
      REG_OBS_GAIN_TWO    = 3'd4,
      REG_OBS_GAIN_INT    = 3'd5,
      REG_REFERENCE_LEVEL = 3'd6
   } osfs_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_COMMIT,
      ST_ZERO
   } osfs_state_type;

   // multiplier operand a
   typedef enum logic [2:0] {
      A_REF,
      A_FIRST,
      A_SECOND,
      A_ERR,
      A_UV
   } osfs_opa_type;

   // multiplier operand b
   typedef enum logic [3:0] {
      B_GAIN_REF,
      B_GAIN_POS,
      B_GAIN_VEL,
      B_PHI11,
      B_PHI21,
      B_OBS_ONE,
      B_OBS_TWO,
      B_OBS_INT,
      B_GAM1,
      B_GAM2
   } osfs_opb_type;

   // accumulator that takes a product
   typedef enum logic [1:0] {
      DST_U,
      DST_N1,
      DST_N2,
      DST_ND
   } osfs_dst_type;

   typedef struct packed {
      osfs_opa_type a_sel;
      osfs_opb_type b_sel;
      osfs_dst_type dst;
      logic         sub;
   } osfs_mop_type;

   typedef struct packed {
      logic         load;
      logic         mul_valid;
      osfs_mop_type mop;
      logic         ref_negative;
      logic         commit;
      logic         zero_out;
   } osfs_cmd_type;

   typedef struct packed {
      logic [GainW-1:0]  gain_pos;
      logic [GainW-1:0]  gain_vel;
      logic [GainW-1:0]  gain_ref;
      logic [GainW-1:0]  obs_gain_one;
      logic [GainW-1:0]  obs_gain_two;
      logic [GainW-1:0]  obs_gain_int;
      logic [LevelW-1:0] reference_level;
   } osfs_cfg_type;

   // multiply schedule: control law first, then observer update
   function automatic osfs_mop_type step_mop(input logic [StepW-1:0] step);
      osfs_mop_type m;
      m = '{a_sel: A_REF, b_sel: B_GAIN_REF, dst: DST_U, sub: 1'b0};
      unique case (step)
         4'd0: m = '{a_sel: A_REF,    b_sel: B_GAIN_REF, dst: DST_U,  sub: 1'b0};
         4'd1: m = '{a_sel: A_FIRST,  b_sel: B_GAIN_POS, dst: DST_U,  sub: 1'b1};
         4'd2: m = '{a_sel: A_SECOND, b_sel: B_GAIN_VEL, dst: DST_U,  sub: 1'b1};
         4'd3: m = '{a_sel: A_FIRST,  b_sel: B_PHI11,    dst: DST_N1, sub: 1'b0};
         4'd4: m = '{a_sel: A_FIRST,  b_sel: B_PHI21,    dst: DST_N2, sub: 1'b0};
         4'd5: m = '{a_sel: A_ERR,    b_sel: B_OBS_ONE,  dst: DST_N1, sub: 1'b0};
         4'd6: m = '{a_sel: A_ERR,    b_sel: B_OBS_TWO,  dst: DST_N2, sub: 1'b0};
         4'd7: m = '{a_sel: A_ERR,    b_sel: B_OBS_INT,  dst: DST_ND, sub: 1'b0};
         4'd8: m = '{a_sel: A_UV,     b_sel: B_GAM1,     dst: DST_N1, sub: 1'b0};
         4'd9: m = '{a_sel: A_UV,     b_sel: B_GAM2,     dst: DST_N2, sub: 1'b0};
         default: m = '{a_sel: A_REF, b_sel: B_GAIN_REF, dst: DST_U, sub: 1'b0};
      endcase
      return m;
   endfunction

   // clamp an accumulator value to the signed state range
   function automatic logic signed [StateW-1:0] sat_state(input logic signed [AccW-1:0] x);
      logic fits;
      fits = (&x[AccW-1:StateW-1]) | ~(|x[AccW-1:StateW-1]);
      if (fits) begin
         return x[StateW-1:0];
      end else if (x[AccW-1]) begin
         return {1'b1, {(StateW-1){1'b0}}};
      end else begin
         return {1'b0, {(StateW-1){1'b1}}};
      end
   endfunction

   // integer part truncated toward zero, clamped to the drive range
   function automatic logic signed [DriveW-1:0] sat_drive(input logic signed [AccW-1:0] x);
      logic signed [AccW-1:0] q;
      q = x >>> FracW;
      if (x[AccW-1] && (|x[FracW-1:0])) begin
         q = q + AccW'(1);
      end
      if (q > DriveMaxAcc) begin
         return DriveMaxAcc[DriveW-1:0];
      end else if (q < DriveMinAcc) begin
         return DriveMinAcc[DriveW-1:0];
      end else begin
         return q[DriveW-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/osfs_req_if.sv =====
// input channel: tick or command beat
interface osfs_req_if import osfs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic signed [SampleW-1:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink (input valid, input opcode, input sample, output ready);
endinterface

// ===== rtl/core/osfs_rsp_if.sv =====
// result channel: drive beat
interface osfs_rsp_if import osfs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DriveW-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink (input valid, input drive, output ready);
endinterface

// ===== rtl/core/observer_state_feedback_servo_top.sv =====
// Position servo with state feedback, a two-state observer and an integral disturbance
// estimate. Each req beat is a tick carrying an ADC sample or a start, stop or
// reference-flip command; every TICKS_PER_STEP-th tick yields one rsp beat with the drive.
// Commands and intermediate ticks are handled in the idle state alone. A step tick while
// stopped passes through the zero state and returns a drive of zero. A step tick while running
// seeds the accumulators on acceptance, runs ten products through the single shared 38x21
// multiplier, adds the last product in the drain state, then commits the states and loads the
// drive register in the commit state. A step also waits while an earlier drive beat has not
// yet been taken. Gains are written through the csr port; the user must write them only while
// the block is idle, the block itself does not enforce it.
module observer_state_feedback_servo_top import osfs_pkg::*; #(
   parameter int TICKS_PER_STEP = 5
) (
   input  logic                clock,
   input  logic                reset,
   osfs_req_if.sink            req_if,
   osfs_rsp_if.source          rsp_if,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   osfs_cfg_type cfg;
   osfs_cmd_type cmd;
   logic         req_ready;
   logic         rsp_valid;

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

   // register bank
   osfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   osfs_ctrl #(
      .TICKS_PER_STEP (TICKS_PER_STEP)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_opcode (osfs_opcode_type'(req_if.opcode)),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // arithmetic
   osfs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_sample (req_if.sample),
      .cmd        (cmd),
      .rsp_drive  (rsp_if.drive)
   );

endmodule

// ===== rtl/core/osfs_csr.sv =====
// configuration registers behind the apb-style port
module osfs_csr import osfs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready,
   output osfs_cfg_type        cfg
);

   osfs_cfg_type cfg_ff;
   osfs_cfg_type cfg_in;
   osfs_reg_type reg_idx;
   logic         wr_en;

   assign reg_idx    = osfs_reg_type'(csr_paddr[CsrAddrW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GAIN_POS:        cfg_in.gain_pos        = csr_pwdata[GainW-1:0];
            REG_GAIN_VEL:        cfg_in.gain_vel        = csr_pwdata[GainW-1:0];
            REG_GAIN_REF:        cfg_in.gain_ref        = csr_pwdata[GainW-1:0];
            REG_OBS_GAIN_ONE:    cfg_in.obs_gain_one    = csr_pwdata[GainW-1:0];
            REG_OBS_GAIN_TWO:    cfg_in.obs_gain_two    = csr_pwdata[GainW-1:0];
            REG_OBS_GAIN_INT:    cfg_in.obs_gain_int    = csr_pwdata[GainW-1:0];
            REG_REFERENCE_LEVEL: cfg_in.reference_level = csr_pwdata[LevelW-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_GAIN_POS:        csr_prdata = CsrDataW'(cfg_ff.gain_pos);
         REG_GAIN_VEL:        csr_prdata = CsrDataW'(cfg_ff.gain_vel);
         REG_GAIN_REF:        csr_prdata = CsrDataW'(cfg_ff.gain_ref);
         REG_OBS_GAIN_ONE:    csr_prdata = CsrDataW'(cfg_ff.obs_gain_one);
         REG_OBS_GAIN_TWO:    csr_prdata = CsrDataW'(cfg_ff.obs_gain_two);
         REG_OBS_GAIN_INT:    csr_prdata = CsrDataW'(cfg_ff.obs_gain_int);
         REG_REFERENCE_LEVEL: csr_prdata = CsrDataW'(cfg_ff.reference_level);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_pos        <= GainPosReset;
         cfg_ff.gain_vel        <= GainVelReset;
         cfg_ff.gain_ref        <= GainRefReset;
         cfg_ff.obs_gain_one    <= ObsOneReset;
         cfg_ff.obs_gain_two    <= ObsTwoReset;
         cfg_ff.obs_gain_int    <= ObsIntReset;
         cfg_ff.reference_level <= RefLevelReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/osfs_ctrl.sv =====
// controller: command decode, tick divider and multiply sequencer
module osfs_ctrl import osfs_pkg::*; #(
   parameter int TICKS_PER_STEP = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  osfs_opcode_type req_opcode,
   output logic            req_ready,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output osfs_cmd_type    cmd
);

   localparam int TickW = $clog2(TICKS_PER_STEP + 1);
   localparam logic [TickW-1:0] TickLast = TickW'(TICKS_PER_STEP);
   localparam logic [StepW-1:0] StepLast = StepW'(StepCount - 1);

   osfs_state_type   state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [TickW-1:0] tick_ff, tick_in;
   logic             running_ff, running_in;
   logic             ref_neg_ff, ref_neg_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic [TickW-1:0] tick_next;
   logic             step_tick;
   logic             slot_free;
   logic             publish;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign tick_next = tick_ff + TickW'(1);
   assign step_tick = (tick_next >= TickLast);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign publish   = ((state_ff == ST_COMMIT) || (state_ff == ST_ZERO)) && slot_free;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (accept && (req_opcode == OP_TICK) && step_tick) begin
               state_in = running_ff ? ST_MUL : ST_ZERO;
            end
         end
         ST_MUL: begin
            if (step_ff == StepLast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_COMMIT;
         ST_COMMIT, ST_ZERO: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and control registers
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      step_in      = step_ff;
      tick_in      = tick_ff;
      running_in   = running_ff;
      ref_neg_in   = ref_neg_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || publish;

      cmd              = '0;
      cmd.mop          = step_mop(step_ff);
      cmd.ref_negative = ref_neg_ff;
      cmd.mul_valid    = (state_ff == ST_MUL);
      cmd.commit       = (state_ff == ST_COMMIT) && slot_free;
      cmd.zero_out     = (state_ff == ST_ZERO) && slot_free;

      // command and tick beats
      if (accept) begin
         unique case (req_opcode)
            OP_TICK: begin
               tick_in  = step_tick ? '0 : tick_next;
               cmd.load = step_tick && running_ff;
            end
            OP_START: running_in = 1'b1;
            OP_STOP:  running_in = 1'b0;
            OP_FLIP:  ref_neg_in = !ref_neg_ff;
            default:  running_in = running_ff;
         endcase
      end

      // multiply step counter
      if (state_ff == ST_MUL) begin
         step_in = (step_ff == StepLast) ? '0 : step_ff + StepW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         tick_ff      <= '0;
         running_ff   <= 1'b0;
         ref_neg_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         tick_ff      <= tick_in;
         running_ff   <= running_in;
         ref_neg_ff   <= ref_neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/osfs_datapath.sv =====
// datapath: shared multiplier, accumulators, observer states, drive register
module osfs_datapath import osfs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  osfs_cfg_type              cfg,
   input  logic signed [SampleW-1:0] req_sample,
   input  osfs_cmd_type              cmd,
   output logic signed [DriveW-1:0]  rsp_drive
);

   logic signed [StateW-1:0] first_ff, first_in;
   logic signed [StateW-1:0] second_ff, second_in;
   logic signed [StateW-1:0] dist_ff, dist_in;
   logic signed [AccW-1:0]   err_ff, err_in;
   logic signed [AccW-1:0]   u_ff, u_in;
   logic signed [AccW-1:0]   uv_ff, uv_in;
   logic signed [AccW-1:0]   n1_ff, n1_in;
   logic signed [AccW-1:0]   n2_ff, n2_in;
   logic signed [AccW-1:0]   nd_ff, nd_in;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic                     pend_ff, pend_in;
   osfs_dst_type             pend_dst_ff, pend_dst_in;
   logic                     pend_sub_ff, pend_sub_in;
   logic signed [DriveW-1:0] drive_ff, drive_in;

   logic signed [SampleW-1:0] ref_val;
   logic signed [MulAW-1:0]   mul_a;
   logic signed [MulBW-1:0]   mul_b;
   logic signed [AccW-1:0]    term;
   logic signed [AccW-1:0]    addend;

   assign rsp_drive = drive_ff;

   // signed reference from magnitude and sign
   always_comb begin
      ref_val = signed'(SampleW'(cfg.reference_level));
      if (cmd.ref_negative) begin
         ref_val = -ref_val;
      end
   end

   // multiplier operand a
   always_comb begin
      case (cmd.mop.a_sel)
         A_REF:    mul_a = MulAW'(ref_val) <<< FracW;
         A_FIRST:  mul_a = MulAW'(first_ff);
         A_SECOND: mul_a = MulAW'(second_ff);
         A_ERR:    mul_a = MulAW'(err_ff);
         A_UV:     mul_a = MulAW'(uv_ff);
         default:  mul_a = '0;
      endcase
   end

   // multiplier operand b, gains are unsigned
   always_comb begin
      case (cmd.mop.b_sel)
         B_GAIN_REF: mul_b = signed'(MulBW'(cfg.gain_ref));
         B_GAIN_POS: mul_b = signed'(MulBW'(cfg.gain_pos));
         B_GAIN_VEL: mul_b = signed'(MulBW'(cfg.gain_vel));
         B_PHI11:    mul_b = signed'(MulBW'(Phi11));
         B_PHI21:    mul_b = signed'(MulBW'(Phi21));
         B_OBS_ONE:  mul_b = signed'(MulBW'(cfg.obs_gain_one));
         B_OBS_TWO:  mul_b = signed'(MulBW'(cfg.obs_gain_two));
         B_OBS_INT:  mul_b = signed'(MulBW'(cfg.obs_gain_int));
         B_GAM1:     mul_b = signed'(MulBW'(Gam1));
         B_GAM2:     mul_b = signed'(MulBW'(Gam2));
         default:    mul_b = '0;
      endcase
   end

   // product stage, the accumulate action travels with the product
   always_comb begin
      prod_in     = cmd.mul_valid ? mul_a * mul_b : prod_ff;
      pend_in     = cmd.mul_valid;
      pend_dst_in = cmd.mul_valid ? cmd.mop.dst : pend_dst_ff;
      pend_sub_in = cmd.mul_valid ? cmd.mop.sub : pend_sub_ff;
   end

   // floored q16 product
   assign term   = AccW'(prod_ff >>> FracW);
   assign addend = pend_sub_ff ? -term : term;

   // accumulators, seeded at the start of a step
   always_comb begin
      err_in = err_ff;
      u_in   = u_ff;
      uv_in  = uv_ff;
      n1_in  = n1_ff;
      n2_in  = n2_ff;
      nd_in  = nd_ff;
      if (cmd.load) begin
         err_in = (AccW'(req_sample) <<< FracW) - AccW'(second_ff);
         u_in   = -AccW'(dist_ff);
         uv_in  = '0;
         n1_in  = '0;
         n2_in  = AccW'(second_ff);
         nd_in  = AccW'(dist_ff);
      end else if (pend_ff) begin
         case (pend_dst_ff)
            DST_U: begin
               u_in  = u_ff + addend;
               uv_in = uv_ff + addend;
            end
            DST_N1:  n1_in = n1_ff + addend;
            DST_N2:  n2_in = n2_ff + addend;
            DST_ND:  nd_in = nd_ff + addend;
            default: n1_in = n1_ff;
         endcase
      end
   end

   // state commit and drive register
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      dist_in   = dist_ff;
      drive_in  = drive_ff;
      if (cmd.commit) begin
         first_in  = sat_state(n1_ff);
         second_in = sat_state(n2_ff);
         dist_in   = sat_state(nd_ff);
         drive_in  = sat_drive(u_ff);
      end else if (cmd.zero_out) begin
         drive_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         dist_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         dist_ff   <= dist_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      u_ff        <= u_in;
      uv_ff       <= uv_in;
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      nd_ff       <= nd_in;
      prod_ff     <= prod_in;
      pend_dst_ff <= pend_dst_in;
      pend_sub_ff <= pend_sub_in;
      drive_ff    <= drive_in;
   end

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the servo controller: directed table, random beats, own predictor
module testbench;
   import osfs_pkg::*;

   localparam int TicksPerStep    = 5;
   localparam int QShift          = 16;
   localparam int ItemsPerSetting = 300;
   localparam int SettleCycles    = 24;
   localparam int CycleLimit      = 400000;
   localparam int RegCount        = 7;
   localparam int SettingCount    = 6;

   // address just past the last register, writes there must be dropped
   localparam logic [RegIdxW-1:0] RegBeyond = 3'd7;

   // plant model constants, Q16
   localparam logic [GainW-1:0] KeepFirst     = 20'd65143;
   localparam logic [GainW-1:0] FirstToSecond = 20'd16338;
   localparam logic [GainW-1:0] DriveToFirst  = 20'd7353;
   localparam logic [GainW-1:0] DriveToSecond = 20'd918;

   // register values after reset
   localparam logic [GainW-1:0]  PosGainInit  = 20'd215600;
   localparam logic [GainW-1:0]  VelGainInit  = 20'd116852;
   localparam logic [GainW-1:0]  RefGainInit  = 20'd116852;
   localparam logic [GainW-1:0]  ObsOneInit   = 20'd133438;
   localparam logic [GainW-1:0]  ObsTwoInit   = 20'd81528;
   localparam logic [GainW-1:0]  ObsIntInit   = 20'd210346;
   localparam logic [LevelW-1:0] RefLevelInit = 9'd50;

   localparam longint StateMax = 64'sd2147483647;
   localparam longint StateMin = -64'sd2147483648;
   localparam longint DriveMax = 64'sd511;
   localparam longint DriveMin = -64'sd512;

   localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
   localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};

   typedef enum {
      SET_RESET,
      SET_MAX,
      SET_ZERO,
      SET_WIDE,
      SET_NOMINAL,
      SET_LOW
   } servo_setting_type;

   typedef struct packed {
      osfs_opcode_type           op;
      logic signed [SampleW-1:0] sample;
      logic                      typed_in;
      logic signed [DriveW-1:0]  drive;
   } servo_row_type;

   // directed beats: extremes, every command, stopped and running steps
   localparam int RowCount = 20;
   servo_row_type servo_rows [RowCount] = '{
      '{OP_TICK,  SampleMin,  1'b0, 10'sd0},
      '{OP_TICK,  SampleMax,  1'b0, 10'sd0},
      '{OP_FLIP,  SampleMin,  1'b0, 10'sd0},
      '{OP_TICK,  10'sd0,     1'b0, 10'sd0},
      '{OP_STOP,  SampleMax,  1'b0, 10'sd0},
      '{OP_TICK,  -10'sd1,    1'b0, 10'sd0},
      '{OP_TICK,  SampleMax,  1'b1, 10'sd0},
      '{OP_START, -10'sd1,    1'b0, 10'sd0},
      '{OP_START, 10'sd0,     1'b0, 10'sd0},
      '{OP_TICK,  SampleMax,  1'b0, 10'sd0},
      '{OP_TICK,  SampleMin,  1'b0, 10'sd0},
      '{OP_TICK,  10'sd1,     1'b0, 10'sd0},
      '{OP_TICK,  -10'sd2,    1'b0, 10'sd0},
      '{OP_TICK,  SampleMax,  1'b0, 10'sd0},
      '{OP_FLIP,  10'sd0,     1'b0, 10'sd0},
      '{OP_TICK,  SampleMin,  1'b0, 10'sd0},
      '{OP_TICK,  SampleMin,  1'b0, 10'sd0},
      '{OP_TICK,  10'sd0,     1'b0, 10'sd0},
      '{OP_TICK,  SampleMax,  1'b0, 10'sd0},
      '{OP_TICK,  SampleMin,  1'b0, 10'sd0}
   };

   logic                clock;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   osfs_req_if req_bus ();
   osfs_rsp_if rsp_bus ();

   observer_state_feedback_servo_top #(
      .TICKS_PER_STEP(TicksPerStep)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted controller state and registers
   logic [2:0]         tick_phase;
   logic               ctrl_running;
   logic               ref_negated;
   logic signed [31:0] est_pos;
   logic signed [31:0] est_vel;
   logic signed [31:0] est_dist;
   logic [GainW-1:0]   k_pos;
   logic [GainW-1:0]   k_vel;
   logic [GainW-1:0]   k_ref;
   logic [GainW-1:0]   l_one;
   logic [GainW-1:0]   l_two;
   logic [GainW-1:0]   l_int;
   logic [LevelW-1:0]  ref_level;

   logic signed [DriveW-1:0] expected_drives [$];
   int mismatch_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // exact product with an unsigned Q16 factor, floored to Q16
   function automatic longint q16_mul(input longint a, input logic [GainW-1:0] g);
      longint p;
      p = a * longint'(g);
      return p >>> QShift;
   endfunction

   function automatic logic signed [31:0] clamp_state(input longint x);
      if (x > StateMax) begin
         return 32'sh7FFFFFFF;
      end else if (x < StateMin) begin
         return 32'sh80000000;
      end
      return 32'(x);
   endfunction

   // one beat through the predicted controller, returns 1 when a drive beat is due
   function automatic bit servo_step(input osfs_opcode_type op,
                                     input logic signed [SampleW-1:0] smp,
                                     output logic signed [DriveW-1:0] drive);
      longint r;
      longint u;
      longint uv;
      longint e;
      longint v;
      longint n1;
      longint n2;
      longint nd;
      longint whole;
      drive = '0;
      case (op)
         OP_START: begin
            ctrl_running = 1'b1;
            return 1'b0;
         end
         OP_STOP: begin
            ctrl_running = 1'b0;
            return 1'b0;
         end
         OP_FLIP: begin
            ref_negated = ~ref_negated;
            return 1'b0;
         end
         default: ;
      endcase
      tick_phase = tick_phase + 3'd1;
      if (tick_phase < 3'(TicksPerStep)) begin
         return 1'b0;
      end
      tick_phase = '0;
      if (!ctrl_running) begin
         return 1'b1;
      end
      // control law
      r = longint'(ref_level);
      if (ref_negated) begin
         r = -r;
      end
      v = longint'(est_dist);
      u = q16_mul(r * 65536, k_ref) - q16_mul(longint'(est_pos), k_pos)
          - q16_mul(longint'(est_vel), k_vel) - v;
      e = longint'(smp) * 65536 - longint'(est_vel);
      uv = u + v;
      // observer update with the unsaturated drive
      n1 = q16_mul(longint'(est_pos), KeepFirst) + q16_mul(uv, DriveToFirst) + q16_mul(e, l_one);
      n2 = q16_mul(longint'(est_pos), FirstToSecond) + longint'(est_vel)
           + q16_mul(uv, DriveToSecond) + q16_mul(e, l_two);
      nd = v + q16_mul(e, l_int);
      est_pos  = clamp_state(n1);
      est_vel  = clamp_state(n2);
      est_dist = clamp_state(nd);
      // integer part toward zero, then clamp
      whole = (u >= 0) ? (u >>> QShift) : -((-u) >>> QShift);
      if (whole > DriveMax) begin
         whole = DriveMax;
      end else if (whole < DriveMin) begin
         whole = DriveMin;
      end
      drive = DriveW'(whole);
      return 1'b1;
   endfunction

   function automatic void apply_register(input logic [RegIdxW-1:0] idx,
                                          input logic [CsrDataW-1:0] value);
      case (idx)
         REG_GAIN_POS:        k_pos = value[GainW-1:0];
         REG_GAIN_VEL:        k_vel = value[GainW-1:0];
         REG_GAIN_REF:        k_ref = value[GainW-1:0];
         REG_OBS_GAIN_ONE:    l_one = value[GainW-1:0];
         REG_OBS_GAIN_TWO:    l_two = value[GainW-1:0];
         REG_OBS_GAIN_INT:    l_int = value[GainW-1:0];
         REG_REFERENCE_LEVEL: ref_level = value[LevelW-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [CsrDataW-1:0] register_value(input logic [RegIdxW-1:0] idx);
      case (idx)
         REG_GAIN_POS:        return CsrDataW'(k_pos);
         REG_GAIN_VEL:        return CsrDataW'(k_vel);
         REG_GAIN_REF:        return CsrDataW'(k_ref);
         REG_OBS_GAIN_ONE:    return CsrDataW'(l_one);
         REG_OBS_GAIN_TWO:    return CsrDataW'(l_two);
         REG_OBS_GAIN_INT:    return CsrDataW'(l_int);
         REG_REFERENCE_LEVEL: return CsrDataW'(ref_level);
         default:             return '0;
      endcase
   endfunction

   // one register transfer, setup then access, then the select is dropped before the next one
   task automatic csr_transfer(input bit is_write, input logic [RegIdxW-1:0] idx,
                               input logic [CsrDataW-1:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (is_write) begin
         apply_register(idx, wdata);
      end else if (csr_prdata !== register_value(idx)) begin
         report_mismatch($sformatf("register %0d reads %h, want %h",
                                   idx, csr_prdata, register_value(idx)));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // unless the setting is the reset one, write every register, then read them all back
   task automatic load_settings(input servo_setting_type setting);
      logic [CsrDataW-1:0] value;
      logic [RegIdxW-1:0]  idx;
      if (setting != SET_RESET) begin
         for (int i = 0; i < RegCount; i++) begin
            idx = RegIdxW'(i);
            case (setting)
               SET_MAX:  value = '1;
               SET_ZERO: value = '0;
               SET_WIDE: value = $urandom;
               SET_NOMINAL: begin
                  value = (idx == REG_REFERENCE_LEVEL) ? CsrDataW'($urandom_range(511))
                                                      : CsrDataW'($urandom_range(260000, 60000));
               end
               default: begin
                  value = (idx == REG_REFERENCE_LEVEL) ? CsrDataW'($urandom_range(511))
                                                      : CsrDataW'($urandom_range(131071));
               end
            endcase
            csr_transfer(1'b1, idx, value);
         end
         csr_transfer(1'b1, RegBeyond, $urandom);
      end
      for (int i = 0; i < RegCount; i++) begin
         csr_transfer(1'b0, RegIdxW'(i), '0);
      end
   endtask

   // offer one beat, called and returning at a falling edge
   task automatic send_beat(input osfs_opcode_type op, input logic signed [SampleW-1:0] smp,
                            input bit typed_in, input logic signed [DriveW-1:0] typed_drive);
      logic signed [DriveW-1:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.sample <= smp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (servo_step(op, smp, predicted)) begin
         expected_drives.push_back(typed_in ? typed_drive : predicted);
      end
      @(negedge clock);
   endtask

   // mostly ticks with a sprinkling of commands
   task automatic send_random_beat();
      osfs_opcode_type           op;
      logic signed [SampleW-1:0] smp;
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         op = OP_START;
      end else if (pick < 7) begin
         op = OP_STOP;
      end else if (pick < 11) begin
         op = OP_FLIP;
      end else begin
         op = OP_TICK;
      end
      case ($urandom_range(7)) inside
         0:       smp = SampleMin;
         1:       smp = SampleMax;
         2, 3:    smp = SampleW'(int'($urandom_range(40)) - 20);
         default: smp = SampleW'($urandom);
      endcase
      send_beat(op, smp, 1'b0, '0);
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // drive beat checker
   always @(posedge clock) begin
      logic signed [DriveW-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_drives.size() == 0) begin
            report_mismatch($sformatf("drive beat %0d with nothing expected", rsp_bus.drive));
         end else begin
            want = expected_drives.pop_front();
            if (rsp_bus.drive !== want) begin
               report_mismatch($sformatf("drive %0d, want %0d", rsp_bus.drive, want));
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // stimulus
   initial begin
      servo_setting_type setting;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_TICK;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_idle_pct  = 9;
      recv_idle_pct  = 50;
      tick_phase     = '0;
      ctrl_running   = 1'b0;
      ref_negated    = 1'b0;
      est_pos        = '0;
      est_vel        = '0;
      est_dist       = '0;
      k_pos          = PosGainInit;
      k_vel          = VelGainInit;
      k_ref          = RefGainInit;
      l_one          = ObsOneInit;
      l_two          = ObsTwoInit;
      l_int          = ObsIntInit;
      ref_level      = RefLevelInit;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int s = 0; s < SettingCount; s++) begin
         setting = servo_setting_type'(s);
         // idling pattern: slow receiver, then slow sender, then none
         if (s < 2) begin
            send_idle_pct = 9;
            recv_idle_pct = 50;
         end else if (s < 4) begin
            send_idle_pct = 50;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_settings(setting);
         if (setting == SET_RESET) begin
            foreach (servo_rows[i]) begin
               send_beat(servo_rows[i].op, servo_rows[i].sample,
                         servo_rows[i].typed_in, servo_rows[i].drive);
            end
         end
         send_beat(OP_START, SampleW'($urandom), 1'b0, '0);
         repeat (ItemsPerSetting) send_random_beat();
         // let the block go quiet before the registers change
         req_bus.valid <= 1'b0;
         while (expected_drives.size() != 0) @(posedge clock);
         repeat (SettleCycles) @(posedge clock);
         @(negedge clock);
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
